// ===== hw/rtl/pvfe_pkg.sv =====
// Package for the predictive varint frame encoder.
// Holds the frame geometry, opcodes, marker bytes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package pvfe_pkg;

    localparam int FIELDS_PER_FRAME = 12;
    localparam int POS_W            = $clog2(FIELDS_PER_FRAME);
    localparam int POS_TIME         = 1;
    localparam int POS_SIGNED_KEY   = 9;

    localparam int VARINT_MAX = 5;
    localparam int BUF_DEPTH  = 13;
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int END_LEN    = 11;

    typedef logic [7:0] t_byte;
    typedef t_byte t_varint_bytes [VARINT_MAX];
    typedef t_byte t_byte_buf [BUF_DEPTH];

    typedef enum logic [1:0] {
        OP_VALUE   = 2'd0,
        OP_EVENT   = 2'd1,
        OP_END     = 2'd2,
        OP_RESTART = 2'd3
    } t_opcode;

    localparam t_byte MARK_KEY   = 8'h49;
    localparam t_byte MARK_DELTA = 8'h50;
    localparam t_byte MARK_EVENT = 8'h45;
    localparam t_byte END_EVENT_ID = 8'hFF;
    localparam t_byte VARINT_GROUP = 8'h7F;
    localparam t_byte VARINT_CONT  = 8'h80;

    localparam t_byte END_TEXT [END_LEN] = '{
        8'h45, 8'h6E, 8'h64, 8'h20, 8'h6F, 8'h66, 8'h20, 8'h6C, 8'h6F, 8'h67, 8'h00
    };

    localparam logic [0:0] REG_KEY_INTERVAL = 1'b0;
    localparam logic [15:0] KEY_INTERVAL_RESET = 16'd32;

endpackage

// ===== hw/rtl/pvfe_varint.sv =====
// Varint byte former: splits a 32-bit word into 7-bit groups with continuation bits.
// Depends on pvfe_pkg for the byte types and constants.
`timescale 1ns / 1ps

module pvfe_varint (
    input  logic [31:0]            i_word,
    output pvfe_pkg::t_varint_bytes o_bytes,
    output logic [2:0]             o_count
);

    logic [pvfe_pkg::VARINT_MAX-1:0] more;

    always_comb begin
        for (int k = 0; k < pvfe_pkg::VARINT_MAX; k++) begin
            more[k] = (k < pvfe_pkg::VARINT_MAX - 1) ? ((i_word >> (7 * (k + 1))) != 32'd0)
                                                      : 1'b0;
            o_bytes[k] = (pvfe_pkg::t_byte'(i_word >> (7 * k)) & pvfe_pkg::VARINT_GROUP)
                       | (more[k] ? pvfe_pkg::VARINT_CONT : 8'h00);
        end
        o_count = 3'd1 + 3'(more[0]) + 3'(more[1]) + 3'(more[2]) + 3'(more[3]);
    end

endmodule

// ===== hw/rtl/predictive_varint_frame_encoder.sv =====
// Top level of the predictive varint frame encoder: input register, frame history,
// byte assembly and the output byte buffer. Depends on pvfe_pkg and pvfe_varint.
//
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_stall   | i_opcode, i_value, i_event_id
// output  | out       | o_valid / i_stall   | o_out_byte, o_last_byte
// config  | in        | APB psel / penable  | paddr, pwdata, prdata
//
// An item is taken into the input register, then its bytes are formed combinationally
// and loaded into a 13-byte output buffer, which sends one byte per cycle while i_stall is low.
// An item produces up to thirteen bytes (a restart produces none); the bytes of the next
// item are loaded once the buffer is empty or its last byte is leaving.
// Reset is synchronous, clears the control state and sets the key interval to 32.
// A stall on the output holds the buffer and, once the input register is full,
// stalls the input.
`timescale 1ns / 1ps

module predictive_varint_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic signed [31:0] i_value,
    input  logic [7:0]  i_event_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FPF   = pvfe_pkg::FIELDS_PER_FRAME;
    localparam int POS_W = pvfe_pkg::POS_W;
    localparam int BUF   = pvfe_pkg::BUF_DEPTH;
    localparam int CNT_W = pvfe_pkg::CNT_W;

    logic [15:0]        r_key_interval;
    logic               r_in_valid;
    pvfe_pkg::t_opcode  r_in_op;
    logic [31:0]        r_in_value;
    logic [7:0]         r_in_id;

    logic [31:0]        r_last [FPF];
    logic [31:0]        r_older [FPF];
    logic               r_have_history;
    logic [31:0]        r_frame_counter;
    logic [15:0]        r_since_key;
    logic [POS_W-1:0]   r_pos;
    logic               r_in_key;

    pvfe_pkg::t_byte_buf r_buf;
    logic [CNT_W-1:0]    r_cnt;

    pvfe_pkg::t_byte_buf n_buf;
    logic [CNT_W-1:0]    n_cnt;

    logic [15:0]        ki;
    logic               key_now;
    logic               key_eff;
    logic               pos_first;
    logic [31:0]        v;
    logic [31:0]        last_v;
    logic [31:0]        older_v;
    logic [31:0]        pred;
    logic [31:0]        diff;
    logic [31:0]        code_word;
    pvfe_pkg::t_varint_bytes vbytes;
    logic [2:0]         vcount;
    logic               buf_free;
    logic               move;
    logic               cfg_write;

    function automatic logic [31:0] zigzag(input logic [31:0] u);
        zigzag = {u[30:0], 1'b0} ^ {32{u[31]}};
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == pvfe_pkg::REG_KEY_INTERVAL);
    assign prdata    = (paddr[2] == pvfe_pkg::REG_KEY_INTERVAL) ? {16'h0000, r_key_interval}
                                                                : 32'h0000_0000;

    assign pos_first = (r_pos == '0);
    assign ki        = (r_key_interval == 16'd0) ? 16'd1 : r_key_interval;
    assign key_now   = !r_have_history || (r_since_key >= (ki - 16'd1));
    assign key_eff   = pos_first ? key_now : r_in_key;
    assign v         = pos_first ? r_frame_counter : r_in_value;
    assign last_v    = r_last[r_pos];
    assign older_v   = r_older[r_pos];
    assign pred      = (r_pos == POS_W'(pvfe_pkg::POS_TIME)) ? ((last_v << 1) - older_v)
                                                               : last_v;
    assign diff      = v - pred;
    assign code_word = key_eff ? ((r_pos == POS_W'(pvfe_pkg::POS_SIGNED_KEY)) ? zigzag(v) : v)
                               : zigzag(diff);

    pvfe_varint u_varint (
        .i_word  (code_word),
        .o_bytes (vbytes),
        .o_count (vcount)
    );

    assign buf_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && !i_stall);
    assign move     = r_in_valid && ((n_cnt == '0) || buf_free);
    assign o_stall  = r_in_valid && !move;

    assign o_valid     = (r_cnt != '0);
    assign o_out_byte  = r_buf[0];
    assign o_last_byte = (r_cnt == CNT_W'(1));

    always_comb begin
        for (int k = 0; k < BUF; k++) begin
            n_buf[k] = 8'h00;
        end
        n_cnt = '0;
        unique case (r_in_op)
            pvfe_pkg::OP_EVENT: begin
                n_buf[0] = pvfe_pkg::MARK_EVENT;
                n_buf[1] = r_in_id;
                n_cnt    = CNT_W'(2);
            end
            pvfe_pkg::OP_END: begin
                n_buf[0] = pvfe_pkg::MARK_EVENT;
                n_buf[1] = pvfe_pkg::END_EVENT_ID;
                for (int k = 0; k < pvfe_pkg::END_LEN; k++) begin
                    n_buf[k + 2] = pvfe_pkg::END_TEXT[k];
                end
                n_cnt = CNT_W'(pvfe_pkg::END_LEN + 2);
            end
            pvfe_pkg::OP_RESTART: begin
                n_cnt = '0;
            end
            pvfe_pkg::OP_VALUE: begin
                if (key_eff && pos_first) begin
                    n_buf[0] = pvfe_pkg::MARK_KEY;
                    for (int k = 0; k < pvfe_pkg::VARINT_MAX; k++) begin
                        n_buf[k + 1] = vbytes[k];
                    end
                    n_cnt = CNT_W'(vcount) + CNT_W'(1);
                end else if (key_eff) begin
                    for (int k = 0; k < pvfe_pkg::VARINT_MAX; k++) begin
                        n_buf[k] = vbytes[k];
                    end
                    n_cnt = CNT_W'(vcount);
                end else if (pos_first) begin
                    n_buf[0] = pvfe_pkg::MARK_DELTA;
                    n_cnt    = CNT_W'(1);
                end else begin
                    for (int k = 0; k < pvfe_pkg::VARINT_MAX; k++) begin
                        n_buf[k] = vbytes[k];
                    end
                    n_cnt = CNT_W'(vcount);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_interval  <= pvfe_pkg::KEY_INTERVAL_RESET;
            r_in_valid      <= 1'b0;
            r_have_history  <= 1'b0;
            r_frame_counter <= 32'd0;
            r_since_key     <= 16'd0;
            r_pos           <= '0;
            r_in_key        <= 1'b0;
            r_cnt           <= '0;
        end else begin
            if (cfg_write) begin
                r_key_interval <= pwdata[15:0];
            end

            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            if (move && (n_cnt != '0)) begin
                r_cnt <= n_cnt;
            end else if (o_valid && !i_stall) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end

            if (move) begin
                if (r_in_op == pvfe_pkg::OP_RESTART) begin
                    r_have_history  <= 1'b0;
                    r_frame_counter <= 32'd0;
                    r_since_key     <= 16'd0;
                    r_pos           <= '0;
                    r_in_key        <= 1'b0;
                end else if (r_in_op == pvfe_pkg::OP_VALUE) begin
                    if (pos_first) begin
                        r_in_key    <= key_now;
                        r_since_key <= key_now ? 16'd0 : (r_since_key + 16'd1);
                    end
                    if (r_pos == POS_W'(FPF - 1)) begin
                        r_have_history  <= 1'b1;
                        r_frame_counter <= r_frame_counter + 32'd1;
                        r_pos           <= '0;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_op    <= pvfe_pkg::t_opcode'(i_opcode);
            r_in_value <= i_value;
            r_in_id    <= i_event_id;
        end
        if (move && (r_in_op == pvfe_pkg::OP_VALUE)) begin
            r_older[r_pos] <= key_eff ? v : last_v;
            r_last[r_pos]  <= v;
        end
        if (move && (n_cnt != '0)) begin
            r_buf <= n_buf;
        end else if (o_valid && !i_stall) begin
            for (int k = 0; k < BUF - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
            r_buf[BUF-1] <= 8'h00;
        end
    end

endmodule
